// File: design/grr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_pkg: shared types and constants for the group reverse reorder block
// state codes, buffer status bundle, register map and reset values
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int DATA_W = 32;
    localparam int GS_W   = 5;

    // register map, word index
    localparam logic REG_GROUP_SIZE = 1'b0;

    localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 5'd3;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } grr_state_t;

    // output buffer status seen by the sequencer
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } grr_obuf_stat_t;

endpackage

// File: design/grr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_mem: group store
// single write port, single read port, registered read data valid in the next cycle
// ----------------------------------------------------------------------------
module grr_mem
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = 16,
    parameter int AW        = $clog2(MAX_GROUP)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [MAX_GROUP];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/grr_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_obuf: two-entry output buffer
// decouples memory read returns from the result channel stall
// ----------------------------------------------------------------------------
module grr_obuf
    import grr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_value,
    input  logic              push_last,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [DATA_W-1:0] out_value,
    output logic              out_last,
    output grr_obuf_stat_t    stat
);

    logic [DATA_W-1:0] val_reg [2];
    logic              last_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic              pop;

    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;
    assign out_value    = val_reg[rptr_reg];
    assign out_last     = last_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_reg[wptr_reg]  <= push_value;
            last_reg[wptr_reg] <= push_last;
        end
    end

    assign stat.count = count_reg;
    assign stat.pop   = pop;

endmodule

// File: design/grr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_ctrl: fill and drain sequencer
// writes incoming words to the group store, then walks it back out
// ----------------------------------------------------------------------------
module grr_ctrl
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = 16,
    parameter int AW        = $clog2(MAX_GROUP),
    parameter int CW        = $clog2(MAX_GROUP + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GS_W-1:0]   group_size,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              end_of_list,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  grr_obuf_stat_t    stat,
    output logic              push,
    output logic              push_last
);

    localparam int KW = (CW > GS_W) ? CW : GS_W;

    grr_state_t    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] left_reg, left_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          rev_reg, rev_next;
    logic          eol_reg, eol_next;
    logic          rv_reg;
    logic          rtag_reg;

    logic [KW-1:0] gs_ext;
    logic [KW-1:0] k_eff;
    logic [CW-1:0] n_cnt;
    logic          accept;
    logic          full_grp;
    logic          issue;
    logic          room;

    assign gs_ext = KW'(group_size);

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (gs_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (gs_ext > KW'(MAX_GROUP))
        begin
            k_eff = KW'(MAX_GROUP);
        end
        else
        begin
            k_eff = gs_ext;
        end
    end

    assign n_cnt    = fill_reg + CW'(1);
    assign full_grp = (KW'(n_cnt) >= k_eff);
    assign room     = (({1'b0, stat.count} + {2'b00, rv_reg}) < 3'd2) || stat.pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (item_valid && (full_grp || end_of_list))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (room && left_reg == CW'(1))
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // outputs and datapath registers
    always_comb
    begin
        item_stall = 1'b1;
        accept     = 1'b0;
        issue      = 1'b0;
        fill_next  = fill_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        rev_next   = rev_reg;
        eol_next   = eol_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                item_stall = 1'b0;
                accept     = item_valid;
                if (item_valid)
                begin
                    if (full_grp)
                    begin
                        fill_next = '0;
                        left_next = n_cnt;
                        idx_next  = AW'(fill_reg);
                        rev_next  = 1'b1;
                        eol_next  = end_of_list;
                    end
                    else if (end_of_list)
                    begin
                        fill_next = '0;
                        left_next = n_cnt;
                        idx_next  = '0;
                        rev_next  = 1'b0;
                        eol_next  = 1'b1;
                    end
                    else
                    begin
                        fill_next = n_cnt;
                    end
                end
            end
            ST_DRAIN:
            begin
                issue = room;
                if (room)
                begin
                    left_next = left_reg - CW'(1);
                    idx_next  = rev_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign mem_we    = accept;
    assign mem_waddr = AW'(fill_reg);
    assign mem_re    = issue;
    assign mem_raddr = idx_reg;
    assign push      = rv_reg;
    assign push_last = rtag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            rev_reg   <= 1'b0;
            eol_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            rtag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            rev_reg   <= rev_next;
            eol_reg   <= eol_next;
            rv_reg    <= issue;
            rtag_reg  <= issue && eol_reg && (left_reg == CW'(1));
        end
    end

    // a partial group never reaches the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(MAX_GROUP))
        else $error("fill count reached store depth");

    // a returning read always finds space in the output buffer
    a_obuf_room: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (stat.count != 2'd2 || stat.pop))
        else $error("output buffer overflow");

    // draining always has reads left to issue
    a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (left_reg != '0))
        else $error("drain with nothing left");

    // the end flag goes out only on a read issued by a drain
    a_tag_src: assert property (@(posedge clk) disable iff (!rst_n)
        rtag_reg |-> $past(state_reg == ST_DRAIN))
        else $error("end flag without drain");

endmodule

// File: design/group_reverse_reorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reverse_reorder: per-group reversal of a word stream
// full groups leave reversed, a trailing partial group leaves in order
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  ------    ------------------------    ---------------------------
//  input     item_valid / item_stall     value[31:0], end_of_list
//  result    result_valid / result_stall out_value[31:0], out_last
//  config    psel penable pwrite pready  paddr[2:0], pwdata, prdata
//
//  a word that completes a group, or ends the list, is followed by a drain
//  of that group before the next word is taken: the group store has a
//  single read port, one word per cycle while the output buffer has room
//  results leave at one per cycle while not stalled, through a two-entry output buffer
//  group store needs no clearing after reset; only written entries are read
//  result_stall holds back the drain, never drops or repeats a word
// ----------------------------------------------------------------------------
module group_reverse_reorder
    import grr_pkg::*;
#(
    parameter int MAX_GROUP = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic signed [31:0] value,
    input  logic              end_of_list,
    output logic              result_valid,
    input  logic              result_stall,
    output logic signed [31:0] out_value,
    output logic              out_last
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    logic [GS_W-1:0]   gs_reg;
    logic              cfg_wr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              push;
    logic              push_last;
    logic [DATA_W-1:0] obuf_value;
    grr_obuf_stat_t    stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= GROUP_SIZE_RESET;
        end
        else if (cfg_wr && paddr[2] == REG_GROUP_SIZE)
        begin
            gs_reg <= pwdata[GS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_GROUP_SIZE) ? {{(32-GS_W){1'b0}}, gs_reg} : 32'd0;

    grr_ctrl #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_size  (gs_reg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .end_of_list (end_of_list),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .stat        (stat),
        .push        (push),
        .push_last   (push_last)
    );

    grr_mem #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    grr_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_value   (mem_rdata),
        .push_last    (push_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_value    (obuf_value),
        .out_last     (out_last),
        .stat         (stat)
    );

    assign out_value = obuf_value;

endmodule
